>>> design/linear_probe_hash_map_top_macros.svh
// ----------------------------------------------------------------------------
// linear probe hash map assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_MAP_TOP_MACROS_SVH
`define LINEAR_PROBE_HASH_MAP_TOP_MACROS_SVH

// clocked property, off while reset is low
`define LPHM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// property that must hold in the cycle after a stalled output word
`define LPHM_ASSERT_STALL(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (o_m_tvalid && !i_m_tready) |=> (prop)) else $error(msg);

`endif

>>> design/lphm_pkg.sv
// ----------------------------------------------------------------------------
// lphm_pkg
// types and codes of the linear probing hash map
// ----------------------------------------------------------------------------
package lphm_pkg;

    localparam int REQ_W      = 2;
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int STATUS_W   = 3;
    localparam int SLOT_IDX_W = 12;
    localparam int S_DATA_W   = KEY_W + VAL_W;
    localparam int M_DATA_W   = 48;
    localparam int MARK_W     = 2;
    localparam int HASH_STEPS = 3;
    localparam int STEP_W     = $clog2(HASH_STEPS);

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd4;

    localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
    localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
    localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_DONE
    } t_state;

endpackage

>>> design/linear_probe_hash_map_top.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_map_top
// open addressing hash map with linear probing and tombstone removal
// ----------------------------------------------------------------------------
// channel  dir  tdata                              tuser
// s        in   lookup_key, record_value           req_type
// m        out  found_value, slot_index            status
//
// one request at a time: the idle state accepts it, each probed slot takes a
// ram read state, then a check and write state, and the done state loads the
// output word; with a table depth that is not a power of two the home slot is
// first worked out on the shared multiplier (reciprocal estimate, back
// multiply, final correction). after reset the mark ram is swept to empty
// with o_s_tready low. a stalled output word holds the next request in the
// done state until it is taken.
// ----------------------------------------------------------------------------
module linear_probe_hash_map_top #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [lphm_pkg::S_DATA_W-1:0] i_s_tdata,   // lookup_key, record_value
    input  logic [lphm_pkg::REQ_W-1:0]    i_s_tuser,   // req_type
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [lphm_pkg::M_DATA_W-1:0] o_m_tdata,   // found_value, slot_index
    output logic [lphm_pkg::STATUS_W-1:0] o_m_tuser    // status
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam bit POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);
    localparam logic [AW-1:0] SLOT_LAST = AW'(TABLE_DEPTH - 1);
    localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);
    localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / TABLE_DEPTH);
    localparam int DW = lphm_pkg::KEY_W + lphm_pkg::VAL_W;

    lphm_pkg::t_state r_state, n_state;
    logic [AW-1:0]                    r_slot, n_slot;
    logic [AW-1:0]                    r_cnt, n_cnt;
    logic [31:0]                      r_quot, n_quot;
    logic [lphm_pkg::STEP_W-1:0]      r_bit, n_bit;
    logic [31:0]                      r_hash, n_hash;
    logic [lphm_pkg::REQ_W-1:0]       r_req, n_req;
    logic [lphm_pkg::KEY_W-1:0]       r_key, n_key;
    logic [lphm_pkg::VAL_W-1:0]       r_val, n_val;
    logic [lphm_pkg::STATUS_W-1:0]    r_res_status, n_res_status;
    logic [lphm_pkg::VAL_W-1:0]       r_res_fval, n_res_fval;
    logic [AW-1:0]                    r_res_slot, n_res_slot;
    logic                             r_out_valid, n_out_valid;
    logic [lphm_pkg::STATUS_W-1:0]    r_out_status, n_out_status;
    logic [lphm_pkg::VAL_W-1:0]       r_out_fval, n_out_fval;
    logic [lphm_pkg::SLOT_IDX_W-1:0]  r_out_slot, n_out_slot;

    logic [lphm_pkg::KEY_W-1:0]       in_key;
    logic [lphm_pkg::VAL_W-1:0]       in_val;
    logic [31:0]                      key_x37;
    logic [31:0]                      mul_a;
    logic [31:0]                      mul_b;
    logic [63:0]                      mul_prod;
    logic [AW-1:0]                    slot_next;
    logic [AW+lphm_pkg::SLOT_IDX_W-1:0] res_slot_ext;

    logic [DW-1:0]                    rd_data;
    logic [lphm_pkg::MARK_W-1:0]      rd_mark;
    logic                             data_we;
    logic                             mark_we;
    logic [lphm_pkg::MARK_W-1:0]      mark_wdata;

    logic is_lookup, is_used, is_empty, key_eq, probe_last;
    logic ins_take, find_hit, find_stop;

    assign in_key  = i_s_tdata[lphm_pkg::KEY_W-1:0];
    assign in_val  = i_s_tdata[lphm_pkg::S_DATA_W-1:lphm_pkg::KEY_W];
    // key * 37 as shift and add, wraps at 32 bits
    assign key_x37 = {in_key[26:0], 5'b0} + {in_key[29:0], 2'b0} + in_key;

    // shared multiplier: hash times reciprocal, then quotient times depth
    assign mul_a    = (r_bit == '0) ? r_hash : r_quot;
    assign mul_b    = (r_bit == '0) ? RECIP : DEPTH32;
    assign mul_prod = 64'(mul_a) * 64'(mul_b);

    assign slot_next = (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;

    assign is_lookup  = (r_req == lphm_pkg::REQ_SEARCH) || (r_req == lphm_pkg::REQ_REMOVE);
    assign is_used    = (rd_mark == lphm_pkg::MARK_USED);
    assign is_empty   = (rd_mark == lphm_pkg::MARK_EMPTY);
    assign key_eq     = (rd_data[lphm_pkg::KEY_W-1:0] == r_key);
    assign probe_last = (r_cnt == SLOT_LAST);
    assign ins_take   = (r_req == lphm_pkg::REQ_INSERT) && !is_used;
    assign find_hit   = is_lookup && is_used && key_eq;
    assign find_stop  = is_lookup && is_empty;

    assign res_slot_ext = {{lphm_pkg::SLOT_IDX_W{1'b0}}, r_res_slot};

    // next state and datapath
    always_comb begin
        n_state      = r_state;
        n_slot       = r_slot;
        n_cnt        = r_cnt;
        n_quot       = r_quot;
        n_bit        = r_bit;
        n_hash       = r_hash;
        n_req        = r_req;
        n_key        = r_key;
        n_val        = r_val;
        n_res_status = r_res_status;
        n_res_fval   = r_res_fval;
        n_res_slot   = r_res_slot;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_fval   = r_out_fval;
        n_out_slot   = r_out_slot;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            lphm_pkg::S_CLEAR: begin
                n_slot = slot_next;
                if (r_slot == SLOT_LAST) begin
                    n_state = lphm_pkg::S_IDLE;
                end
            end
            lphm_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_req        = i_s_tuser;
                    n_key        = in_key;
                    n_val        = in_val;
                    n_hash       = key_x37;
                    n_quot       = '0;
                    n_bit        = '0;
                    n_cnt        = '0;
                    n_res_status = lphm_pkg::ST_MISSING;
                    n_res_fval   = '0;
                    n_res_slot   = '0;
                    if (i_s_tuser != lphm_pkg::REQ_INSERT &&
                        i_s_tuser != lphm_pkg::REQ_SEARCH &&
                        i_s_tuser != lphm_pkg::REQ_REMOVE) begin
                        n_state = lphm_pkg::S_DONE;
                    end else if (POW2) begin
                        n_slot  = key_x37[AW-1:0];
                        n_state = lphm_pkg::S_PROBE_RD;
                    end else begin
                        n_state = lphm_pkg::S_HASH;
                    end
                end
            end
            lphm_pkg::S_HASH: begin
                n_bit = r_bit + 1'b1;
                if (r_bit == '0) begin
                    // quotient estimate, low by at most one
                    n_quot = mul_prod[63:32];
                end else if (r_bit == lphm_pkg::STEP_W'(lphm_pkg::HASH_STEPS - 1)) begin
                    n_slot  = (r_hash >= DEPTH32) ? AW'(r_hash - DEPTH32) : r_hash[AW-1:0];
                    n_state = lphm_pkg::S_PROBE_RD;
                end else begin
                    // remainder estimate, below twice the depth
                    n_hash = r_hash - mul_prod[31:0];
                end
            end
            lphm_pkg::S_PROBE_RD: begin
                n_state = lphm_pkg::S_PROBE_CHK;
            end
            lphm_pkg::S_PROBE_CHK: begin
                if (ins_take) begin
                    n_res_status = lphm_pkg::ST_INSERTED;
                    n_res_slot   = r_slot;
                    n_state      = lphm_pkg::S_DONE;
                end else if (find_hit) begin
                    n_res_status = (r_req == lphm_pkg::REQ_REMOVE) ? lphm_pkg::ST_REMOVED
                                                                   : lphm_pkg::ST_FOUND;
                    n_res_fval   = rd_data[DW-1:lphm_pkg::KEY_W];
                    n_res_slot   = r_slot;
                    n_state      = lphm_pkg::S_DONE;
                end else if (find_stop) begin
                    n_state = lphm_pkg::S_DONE;
                end else if (probe_last) begin
                    // went once around the table
                    n_res_status = (r_req == lphm_pkg::REQ_INSERT) ? lphm_pkg::ST_FULL
                                                                   : lphm_pkg::ST_MISSING;
                    n_state      = lphm_pkg::S_DONE;
                end else begin
                    n_slot  = slot_next;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = lphm_pkg::S_PROBE_RD;
                end
            end
            lphm_pkg::S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_fval   = r_res_fval;
                    n_out_slot   = res_slot_ext[lphm_pkg::SLOT_IDX_W-1:0];
                    n_state      = lphm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lphm_pkg::S_IDLE;
            end
        endcase
    end

    // ram controls and handshake
    always_comb begin
        o_s_tready = 1'b0;
        data_we    = 1'b0;
        mark_we    = 1'b0;
        mark_wdata = lphm_pkg::MARK_EMPTY;
        case (r_state)
            lphm_pkg::S_CLEAR: begin
                mark_we = 1'b1;
            end
            lphm_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
            end
            lphm_pkg::S_PROBE_CHK: begin
                if (ins_take) begin
                    data_we    = 1'b1;
                    mark_we    = 1'b1;
                    mark_wdata = lphm_pkg::MARK_USED;
                end else if (find_hit && r_req == lphm_pkg::REQ_REMOVE) begin
                    mark_we    = 1'b1;
                    mark_wdata = lphm_pkg::MARK_TOMB;
                end
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lphm_pkg::S_CLEAR;
            r_slot      <= '0;
            r_cnt       <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_cnt       <= n_cnt;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot       <= n_quot;
        r_hash       <= n_hash;
        r_req        <= n_req;
        r_key        <= n_key;
        r_val        <= n_val;
        r_res_status <= n_res_status;
        r_res_fval   <= n_res_fval;
        r_res_slot   <= n_res_slot;
        r_out_status <= n_out_status;
        r_out_fval   <= n_out_fval;
        r_out_slot   <= n_out_slot;
    end

    // key and handle per slot
    lphm_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_DEPTH)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (r_slot),
        .i_wdata ({r_val, r_key}),
        .i_raddr (r_slot),
        .o_rdata (rd_data)
    );

    // empty / used / tombstone per slot
    lphm_ram #(
        .WIDTH (lphm_pkg::MARK_W),
        .DEPTH (TABLE_DEPTH)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (r_slot),
        .i_wdata (mark_wdata),
        .i_raddr (r_slot),
        .o_rdata (rd_mark)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {{(lphm_pkg::M_DATA_W - lphm_pkg::VAL_W - lphm_pkg::SLOT_IDX_W){1'b0}},
                         r_out_slot, r_out_fval};

endmodule

>>> design/lphm_ram.sv
// ----------------------------------------------------------------------------
// lphm_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module lphm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/lphm_checker.sv
// ----------------------------------------------------------------------------
// lphm_checker
// port level checks of the hash map, bound to the top level
// ----------------------------------------------------------------------------
`include "linear_probe_hash_map_top_macros.svh"

module lphm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic [lphm_pkg::S_DATA_W-1:0] i_s_tdata,
    input logic [lphm_pkg::REQ_W-1:0]    i_s_tuser,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [lphm_pkg::M_DATA_W-1:0] o_m_tdata,
    input logic [lphm_pkg::STATUS_W-1:0] o_m_tuser
);

    logic s_fire;
    logic no_hit;

    assign s_fire = i_s_tvalid && o_s_tready && (i_s_tdata == i_s_tdata) &&
                    (i_s_tuser == i_s_tuser);
    assign no_hit = (o_m_tuser == lphm_pkg::ST_MISSING) || (o_m_tuser == lphm_pkg::ST_FULL);

    `LPHM_ASSERT_STALL(a_out_hold, o_m_tvalid, "output word dropped while stalled")

    `LPHM_ASSERT_STALL(a_out_stable, $stable(o_m_tdata) && $stable(o_m_tuser), "word changed")

    // one request in flight: ready drops right after a word is taken
    `LPHM_ASSERT(a_one_in_flight, s_fire |=> !o_s_tready, "second request taken while busy")

    // misses and a full table carry no handle and no slot
    `LPHM_ASSERT(a_miss_zero, (o_m_tvalid && no_hit) |-> (o_m_tdata == '0), "miss with payload")

endmodule

bind linear_probe_hash_map_top lphm_checker u_lphm_checker (.*);
